@@ rtl/core/ckt_pkg.sv @@
package ckt_pkg;

  // table geometry
  localparam int CLIENT_SLOTS = 16;
  localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CLIENT_SLOTS - 1);

  // field widths
  localparam int CMD_W  = 3;
  localparam int KIND_W = 3;
  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int SEQ_W  = 16;
  localparam int LOST_W = 8;
  localparam int ENTRY_W = MAC_W + IP_W + LOST_W;

  // constants
  localparam logic [SEQ_W-1:0]  SEQ_FIRST    = 16'd1;
  localparam logic [SEQ_W-1:0]  SEQ_TOP      = 16'hFFFF;
  localparam logic [LOST_W-1:0] LOST_SAT     = 8'hFF;
  localparam logic [LOST_W-1:0] LOST_RST_VAL = 8'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC  = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_DEAUTH = 3'd3,
    CMD_ECHO   = 3'd4,
    CMD_CHECK  = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_PING    = 3'd1,
    KIND_DISC    = 3'd2,
    KIND_PRESENT = 3'd3,
    KIND_NEW     = 3'd4,
    KIND_FULL    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ACT,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_EMPTY
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [LOST_W-1:0] lost;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [LOST_W-1:0] max_lost;
    logic [MAC_W-1:0]  own_mac;
  } cfg_t;

endpackage

@@ rtl/core/ckt_ram.sv @@
module ckt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/ckt_seq.sv @@
module ckt_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ckt_pkg::CMD_W-1:0]   cmd,
  input  logic [ckt_pkg::MAC_W-1:0]   client_mac,
  input  logic [ckt_pkg::IP_W-1:0]    client_ip,
  input  logic [ckt_pkg::MAC_W-1:0]   frame_dest_mac,
  input  logic [ckt_pkg::SEQ_W-1:0]   reply_seq,
  input  ckt_pkg::cfg_t               cfg,
  input  logic                        out_free,
  output logic                        res_valid,
  output ckt_pkg::res_t               res
);

  import ckt_pkg::*;

  state_t state, state_next;

  logic [CLIENT_SLOTS-1:0] valid, valid_next;
  logic [SEQ_W-1:0]  next_seq;
  logic [SEQ_W-1:0]  last_ping_seq;

  // captured command
  logic [CMD_W-1:0]  cmd_q;
  logic [MAC_W-1:0]  mac_q;
  logic [IP_W-1:0]   ip_q;

  // lookup pipeline
  logic [SLOT_W-1:0] ridx;
  logic              rdone;
  logic              pend;
  logic [SLOT_W-1:0] cidx;
  logic              found;
  logic [SLOT_W-1:0] hit_idx;
  logic [IP_W-1:0]   hit_ip;
  logic              look_hit;

  // tick walk
  logic [SLOT_W-1:0] idx;
  logic              pinged;
  logic              ping_mark;
  logic              seq_step;
  logic              tick_last;
  logic              above_any;

  logic [SLOT_W-1:0] free_idx;
  logic              full;

  // memory port
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            rd;

  ckt_ram #(
    .DEPTH(CLIENT_SLOTS),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd)
  );

  // lowest free slot and table full
  always_comb begin
    free_idx = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end
  assign full = &valid;

  // any occupied slot past the one being walked
  always_comb begin
    above_any = 1'b0;
    for (int i = 0; i < CLIENT_SLOTS; i++) begin
      if (valid[i] && (i > int'(idx))) begin
        above_any = 1'b1;
      end
    end
  end

  assign look_hit = pend && valid[cidx] && (rd.mac == mac_q);

  // next state, memory access and results
  always_comb begin
    state_next = state;
    valid_next = valid;
    in_ready   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = ridx;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = '0;
    res_valid  = 1'b0;
    res        = '0;
    seq_step   = 1'b0;
    ping_mark  = 1'b0;
    tick_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd)
            CMD_TICK:   state_next = (valid == '0) ? ST_TICK_EMPTY : ST_TICK_RD;
            CMD_ADD:    state_next = ST_LOOK;
            CMD_REMOVE: state_next = ST_LOOK;
            CMD_CHECK:  state_next = ST_LOOK;
            CMD_DEAUTH: state_next = (frame_dest_mac == cfg.own_mac) ? ST_LOOK : ST_ACT;
            CMD_ECHO:   state_next = (reply_seq == last_ping_seq) ? ST_LOOK : ST_ACT;
            default:    state_next = ST_ACT;
          endcase
        end
      end
      ST_LOOK: begin
        ram_re    = !rdone;
        ram_raddr = ridx;
        if (look_hit || (pend && cidx == LAST_SLOT)) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        if (out_free) begin
          res_valid  = 1'b1;
          res.kind   = KIND_NONE;
          res.last   = 1'b1;
          state_next = ST_IDLE;
          case (cmd_q)
            CMD_ADD: begin
              if (!found) begin
                res.mac = mac_q;
                res.ip  = ip_q;
                if (full) begin
                  res.kind = KIND_FULL;
                end else begin
                  res.kind   = KIND_NEW;
                  ram_we     = 1'b1;
                  ram_waddr  = free_idx;
                  ram_wdata  = '{mac: mac_q, ip: ip_q, lost: '0};
                  valid_next[free_idx] = 1'b1;
                end
              end
            end
            CMD_REMOVE: begin
              if (found) begin
                valid_next[hit_idx] = 1'b0;
              end
            end
            CMD_DEAUTH: begin
              if (found) begin
                res.kind = KIND_DISC;
                res.mac  = mac_q;
                res.ip   = hit_ip;
                valid_next[hit_idx] = 1'b0;
              end
            end
            CMD_ECHO: begin
              if (found) begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx;
                ram_wdata = '{mac: mac_q, ip: hit_ip, lost: '0};
              end
            end
            CMD_CHECK: begin
              if (found) begin
                res.kind = KIND_PRESENT;
                res.mac  = mac_q;
                res.ip   = hit_ip;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK_RD: begin
        if (valid[idx]) begin
          ram_re     = 1'b1;
          ram_raddr  = idx;
          state_next = ST_TICK_EV;
        end
      end
      ST_TICK_EV: begin
        if (out_free) begin
          tick_last = !above_any;
          res_valid = 1'b1;
          res.mac   = rd.mac;
          res.ip    = rd.ip;
          res.last  = tick_last;
          if (rd.lost >= cfg.max_lost) begin
            res.kind = KIND_DISC;
            valid_next[idx] = 1'b0;
          end else begin
            res.kind  = KIND_PING;
            res.seq   = next_seq;
            ping_mark = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = idx;
            ram_wdata = '{mac: rd.mac, ip: rd.ip,
                          lost: (rd.lost == LOST_SAT) ? LOST_SAT : rd.lost + LOST_W'(1)};
          end
          if (tick_last) begin
            seq_step   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_TICK_RD;
          end
        end
      end
      ST_TICK_EMPTY: begin
        if (out_free) begin
          res_valid  = 1'b1;
          res.kind   = KIND_NONE;
          res.last   = 1'b1;
          seq_step   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, occupancy and sequence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      next_seq      <= SEQ_FIRST;
      last_ping_seq <= '0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      if (seq_step) begin
        if (pinged || ping_mark) begin
          last_ping_seq <= next_seq;
        end
        next_seq <= (next_seq >= SEQ_TOP) ? SEQ_FIRST : next_seq + SEQ_W'(1);
      end
    end
  end

  // capture the command and run the lookup and walk counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_q  <= cmd;
      mac_q  <= client_mac;
      ip_q   <= client_ip;
      found  <= 1'b0;
      idx    <= '0;
      ridx   <= '0;
      rdone  <= 1'b0;
      pend   <= 1'b0;
      pinged <= 1'b0;
    end
    if (state == ST_LOOK) begin
      if (!rdone) begin
        ridx <= ridx + SLOT_W'(1);
        if (ridx == LAST_SLOT) begin
          rdone <= 1'b1;
        end
      end
      pend <= !rdone;
      cidx <= ridx;
      if (look_hit) begin
        found   <= 1'b1;
        hit_idx <= cidx;
        hit_ip  <= rd.ip;
      end
    end
    // advance the walk past a free slot or a finished one
    if ((state == ST_TICK_RD && !valid[idx]) ||
        (state == ST_TICK_EV && out_free && !tick_last)) begin
      idx <= idx + SLOT_W'(1);
    end
    if (ping_mark) begin
      pinged <= 1'b1;
    end
  end

endmodule

@@ rtl/core/client_keepalive_table_top.sv @@
// Keep-alive client table. Holds up to CLIENT_SLOTS clients (MAC, IP, lost
// ping count) in a single-port-read RAM with a registered read; occupancy
// lives in flip-flops, so the table is empty straight out of reset and no
// clearing pass runs. One command is in flight at a time. Add, remove,
// deauth, echo reply and check scan the RAM one slot per cycle; a deauth
// to a foreign address, an echo with a stale sequence, a tick on an empty
// table and unknown commands skip the scan. A tick walks the table: each
// occupied slot is read and then gives its result, free slots are passed
// over, and the walk ends at the last occupied slot. Every result waits
// while the output register is not free. The scan and the walk go one slot
// at a time because of the one RAM read port. Results go through an output
// register, so a new command is taken while the final result of the
// previous one still waits.
module client_keepalive_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ckt_pkg::CMD_W-1:0]     cmd,
  input  logic [ckt_pkg::MAC_W-1:0]     client_mac,
  input  logic [ckt_pkg::IP_W-1:0]      client_ip,
  input  logic [ckt_pkg::MAC_W-1:0]     frame_dest_mac,
  input  logic [ckt_pkg::SEQ_W-1:0]     reply_seq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ckt_pkg::KIND_W-1:0]    kind,
  output logic [ckt_pkg::MAC_W-1:0]     out_mac,
  output logic [ckt_pkg::IP_W-1:0]      out_ip,
  output logic [ckt_pkg::SEQ_W-1:0]     ping_seq,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckt_pkg::MAC_W-1:0]     cfg_data
);

  import ckt_pkg::*;

  cfg_t  cfg;
  logic  out_free;
  logic  res_valid;
  res_t  res;
  res_t  res_q;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_lost <= LOST_RST_VAL;
      cfg.own_mac  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_LOST: cfg.max_lost <= cfg_data[LOST_W-1:0];
        REG_OWN_MAC:  cfg.own_mac  <= cfg_data;
        default: ;
      endcase
    end
  end

  ckt_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .client_mac    (client_mac),
    .client_ip     (client_ip),
    .frame_dest_mac(frame_dest_mac),
    .reply_seq     (reply_seq),
    .cfg           (cfg),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register: load a result when empty or being drained
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign kind     = res_q.kind;
  assign out_mac  = res_q.mac;
  assign out_ip   = res_q.ip;
  assign ping_seq = res_q.seq;
  assign last     = res_q.last;

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result produced while output register is occupied");

  // a command is never taken while the sequencer is producing a result
  a_idle_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && res_valid))
    else $error("input accepted while a result is being produced");

  // a ping never carries sequence zero
  a_ping_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PING) |-> (ping_seq != '0))
    else $error("ping request with zero sequence");

  // an empty result always closes its command
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NONE) |-> last)
    else $error("empty result not marked last");

endmodule

@@ tb/tb_client_keepalive_table_top.sv @@
module tb_client_keepalive_table_top;
  import ckt_pkg::*;

  localparam int IDLE_PCT     = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 2 * CLIENT_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int POOL_SIZE    = CLIENT_SLOTS + 4;

  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam logic [MAC_W-1:0] MAC_ONES  = '1;
  localparam logic [IP_W-1:0]  IP_ONES   = '1;
  localparam logic [SEQ_W-1:0] SEQ_ONES  = '1;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] dest;
    logic [SEQ_W-1:0] seq;
    bit               typed;
    kind_t            t_kind;
    logic [MAC_W-1:0] t_mac;
    logic [IP_W-1:0]  t_ip;
  } table_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [MAC_W-1:0] client_mac = '0;
  logic [IP_W-1:0]  client_ip = '0;
  logic [MAC_W-1:0] frame_dest_mac = '0;
  logic [SEQ_W-1:0] reply_seq = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [MAC_W-1:0]  out_mac;
  logic [IP_W-1:0]   out_ip;
  logic [SEQ_W-1:0]  ping_seq;
  logic              last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAC_W-1:0]     cfg_data = '0;

  // shadow of the client table and its registers
  bit               slot_used [CLIENT_SLOTS];
  logic [MAC_W-1:0] slot_mac  [CLIENT_SLOTS];
  logic [IP_W-1:0]  slot_ip   [CLIENT_SLOTS];
  logic [LOST_W-1:0] slot_lost [CLIENT_SLOTS];
  logic [SEQ_W-1:0] seq_next = SEQ_FIRST;
  logic [SEQ_W-1:0] seq_last_ping = '0;
  logic [LOST_W-1:0] cfg_max_lost = LOST_RST_VAL;
  logic [MAC_W-1:0] cfg_own_mac = '0;

  res_t       notices_due [$];
  table_cmd_t cmd_backlog [$];
  table_cmd_t offered;
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  client_keepalive_table_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .client_mac(client_mac), .client_ip(client_ip),
    .frame_dest_mac(frame_dest_mac), .reply_seq(reply_seq),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_mac(out_mac), .out_ip(out_ip),
    .ping_seq(ping_seq), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic res_t notice(kind_t k, logic [MAC_W-1:0] m, logic [IP_W-1:0] a,
                                  logic [SEQ_W-1:0] s);
    res_t r;
    r.kind = k;
    r.mac  = m;
    r.ip   = a;
    r.seq  = s;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic table_cmd_t row(logic [CMD_W-1:0] c, logic [MAC_W-1:0] m,
                                     logic [IP_W-1:0] a, logic [MAC_W-1:0] d,
                                     logic [SEQ_W-1:0] s, bit t, kind_t k,
                                     logic [MAC_W-1:0] km, logic [IP_W-1:0] ka);
    table_cmd_t it;
    it.cmd = c;
    it.mac = m;
    it.ip = a;
    it.dest = d;
    it.seq = s;
    it.typed = t;
    it.t_kind = k;
    it.t_mac = km;
    it.t_ip = ka;
    return it;
  endfunction

  // lowest occupied slot holding this MAC, or -1
  function automatic int find_client(logic [MAC_W-1:0] m);
    for (int i = 0; i < CLIENT_SLOTS; i++)
      if (slot_used[i] && slot_mac[i] == m) return i;
    return -1;
  endfunction

  // apply one command to the shadow table and queue the notices it causes
  task automatic take_command(input table_cmd_t it);
    res_t batch [$];
    int slot;
    bit pinged;
    pinged = 1'b0;
    slot = -1;
    case (it.cmd)
      CMD_TICK: begin
        for (int i = 0; i < CLIENT_SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_lost[i] >= cfg_max_lost) begin
              batch.push_back(notice(KIND_DISC, slot_mac[i], slot_ip[i], '0));
              slot_used[i] = 1'b0;
            end else begin
              batch.push_back(notice(KIND_PING, slot_mac[i], slot_ip[i], seq_next));
              if (slot_lost[i] != LOST_SAT) slot_lost[i] = slot_lost[i] + 1'b1;
              pinged = 1'b1;
            end
          end
        end
        if (pinged) seq_last_ping = seq_next;
        seq_next = (seq_next >= SEQ_TOP) ? SEQ_FIRST : seq_next + 1'b1;
      end
      CMD_ADD: begin
        if (find_client(it.mac) < 0) begin
          for (int i = CLIENT_SLOTS - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
          if (slot < 0) begin
            batch.push_back(notice(KIND_FULL, it.mac, it.ip, '0));
          end else begin
            slot_used[slot] = 1'b1;
            slot_mac[slot] = it.mac;
            slot_ip[slot] = it.ip;
            slot_lost[slot] = '0;
            batch.push_back(notice(KIND_NEW, it.mac, it.ip, '0));
          end
        end
      end
      CMD_REMOVE: begin
        slot = find_client(it.mac);
        if (slot >= 0) slot_used[slot] = 1'b0;
      end
      CMD_DEAUTH: begin
        if (it.dest == cfg_own_mac) begin
          slot = find_client(it.mac);
          if (slot >= 0) begin
            batch.push_back(notice(KIND_DISC, slot_mac[slot], slot_ip[slot], '0));
            slot_used[slot] = 1'b0;
          end
        end
      end
      CMD_ECHO: begin
        if (it.seq == seq_last_ping) begin
          slot = find_client(it.mac);
          if (slot >= 0) slot_lost[slot] = '0;
        end
      end
      CMD_CHECK: begin
        slot = find_client(it.mac);
        if (slot >= 0)
          batch.push_back(notice(KIND_PRESENT, slot_mac[slot], slot_ip[slot], '0));
      end
      default: ;
    endcase
    if (batch.size() == 0) batch.push_back(notice(KIND_NONE, '0, '0, '0));
    // a hand-typed row overrides what the shadow computed
    if (it.typed) begin
      batch.delete();
      batch.push_back(notice(it.t_kind, it.t_mac, it.t_ip, '0));
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) notices_due.push_back(batch[k]);
  endtask

  // random command, biased toward well-formed traffic on known clients
  function automatic table_cmd_t random_command();
    table_cmd_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = row(CMD_TICK, mac_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom(), rand_mac(),
             16'($urandom()), 1'b0, KIND_NONE, '0, '0);
    if ($urandom_range(0, 9) == 0) it.mac = rand_mac();
    if (pick < 28) begin
      it.cmd = CMD_ADD;
    end else if (pick < 48) begin
      it.cmd = CMD_TICK;
    end else if (pick < 63) begin
      it.cmd = CMD_ECHO;
      if ($urandom_range(0, 9) < 7) it.seq = seq_last_ping;
    end else if (pick < 73) begin
      it.cmd = CMD_CHECK;
    end else if (pick < 83) begin
      it.cmd = CMD_DEAUTH;
      if ($urandom_range(0, 9) < 7) it.dest = cfg_own_mac;
    end else if (pick < 93) begin
      it.cmd = CMD_REMOVE;
    end else begin
      it.cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    end
    return it;
  endfunction

  // command channel: offer queued commands, drop valid at random between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_command(offered);
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          cmd <= offered.cmd;
          client_mac <= offered.mac;
          client_ip <= offered.ip;
          frame_dest_mac <= offered.dest;
          reply_seq <= offered.seq;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result channel: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // compare each result transfer with the oldest pending notice
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (notices_due.size() == 0) begin
        $display("%0t: unexpected result kind %0d mac %h", $time, kind, out_mac);
        fail_count++;
      end else begin
        want = notices_due.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
          fail_count++;
        end
        if (out_mac !== want.mac) begin
          $display("%0t: out_mac expected %h got %h", $time, want.mac, out_mac);
          fail_count++;
        end
        if (out_ip !== want.ip) begin
          $display("%0t: out_ip expected %h got %h", $time, want.ip, out_ip);
          fail_count++;
        end
        if (ping_seq !== want.seq) begin
          $display("%0t: ping_seq expected %0d got %0d", $time, want.seq, ping_seq);
          fail_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d got %0d", $time, want.last, last);
          fail_count++;
        end
      end
    end
  end

  // hard stop
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("client_keepalive_table_top verification failed");
    $finish;
  end

  // write one register through the config channel and mirror it
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_LOST) cfg_max_lost = value[LOST_W-1:0];
    else if (idx == REG_OWN_MAC) cfg_own_mac = value;
  endtask

  // wait until every command is taken and every notice has arrived;
  // look between edges so the driver's updates of this edge have settled
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || notices_due.size() != 0);
  endtask

  // feed random commands one at a time so echo sequences stay current
  task automatic feed_random(input int count);
    repeat (count) begin
      while (cmd_backlog.size() != 0) @(posedge clk);
      cmd_backlog.push_back(random_command());
    end
  endtask

  initial begin
    table_cmd_t directed [$];
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_mac[i] = '0;
      slot_ip[i] = '0;
      slot_lost[i] = '0;
    end
    foreach (mac_pool[i]) mac_pool[i] = rand_mac();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed pass under reset register values (limit 5, own MAC zero)
    directed.push_back(row(CMD_TICK, '0, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_ECHO, MAC_ONES, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_CHECK, MAC_ONES, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_ADD, MAC_ONES, IP_ONES, '0, '0, 1'b1, KIND_NEW,
                           MAC_ONES, IP_ONES));
    directed.push_back(row(CMD_ADD, '0, '0, '0, '0, 1'b1, KIND_NEW, '0, '0));
    // already present: no result, IP left alone
    directed.push_back(row(CMD_ADD, MAC_ONES, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_CHECK, MAC_ONES, '0, '0, '0, 1'b1, KIND_PRESENT,
                           MAC_ONES, IP_ONES));
    // echo with sequence zero before any ping was sent
    directed.push_back(row(CMD_ECHO, '0, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_TICK, '0, '0, '0, '0, 1'b0, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_ECHO, '0, '0, '0, SEQ_ONES, 1'b1, KIND_NONE, '0, '0));
    // matches the ping of the tick above (second sequence value)
    directed.push_back(row(CMD_ECHO, '0, '0, '0, 16'd2, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_TICK, '0, '0, '0, '0, 1'b0, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_DEAUTH, MAC_ONES, '0, '0, '0, 1'b1, KIND_DISC,
                           MAC_ONES, IP_ONES));
    directed.push_back(row(CMD_DEAUTH, '0, '0, MAC_ONES, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_CHECK, '0, '0, '0, '0, 1'b1, KIND_PRESENT, '0, '0));
    directed.push_back(row(CMD_TICK, '0, '0, '0, '0, 1'b0, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_REMOVE, '0, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_REMOVE, MAC_ONES, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    directed.push_back(row(CMD_RSVD6, MAC_ONES, IP_ONES, MAC_ONES, SEQ_ONES, 1'b1,
                           KIND_NONE, '0, '0));
    directed.push_back(row(CMD_RSVD7, MAC_ONES, IP_ONES, MAC_ONES, SEQ_ONES, 1'b1,
                           KIND_NONE, '0, '0));
    directed.push_back(row(CMD_TICK, '0, '0, '0, '0, 1'b1, KIND_NONE, '0, '0));
    foreach (directed[i]) cmd_backlog.push_back(directed[i]);
    drain();

    // limit one, the shortest that still pings: clients drop on every second tick
    set_register(REG_MAX_LOST, 48'd1);
    set_register(REG_OWN_MAC, rand_mac());
    feed_random(45);
    drain();

    // widest window, fill the table past full, then starve the result side
    set_register(REG_MAX_LOST, 48'(LOST_SAT));
    set_register(REG_OWN_MAC, MAC_ONES);
    for (int i = 0; i <= CLIENT_SLOTS; i++)
      cmd_backlog.push_back(row(CMD_ADD, mac_pool[i], $urandom(), '0, '0, 1'b0,
                                KIND_NONE, '0, '0));
    hold_req <= 1'b1;
    feed_random(45);
    drain();

    // zero limit: every client goes at the next tick
    set_register(REG_MAX_LOST, 48'd0);
    set_register(REG_OWN_MAC, '0);
    feed_random(20);
    drain();

    // moderate limit, first a stretch with no stalls on either side
    set_register(REG_MAX_LOST, 48'($urandom_range(2, 8)));
    set_register(REG_OWN_MAC, mac_pool[$urandom_range(0, POOL_SIZE - 1)]);
    steady <= 1'b1;
    feed_random(40);
    steady <= 1'b0;
    feed_random(40);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("client_keepalive_table_top verification clean");
    end else begin
      $display("client_keepalive_table_top verification failed");
    end
    $finish;
  end

endmodule

@@ client_keepalive_table_top.f @@
rtl/core/ckt_pkg.sv
rtl/core/ckt_ram.sv
rtl/core/ckt_seq.sv
rtl/core/client_keepalive_table_top.sv
tb/tb_client_keepalive_table_top.sv
